// ----- hw/rtl/angle_to_sexagesimal_unit_assert.svh -----
// Assertion macros shared by the angle to sexagesimal RTL.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef ANGLE_TO_SEXAGESIMAL_UNIT_ASSERT_SVH
`define ANGLE_TO_SEXAGESIMAL_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/asx_pkg.sv -----
// Shared constants and types of the angle to sexagesimal converter.
// Depends on nothing; used by the interfaces and all RTL modules.
package asx_pkg;

    // Fixed field widths.
    localparam int ANGLE_W = 40;
    localparam int WHOLE_W = 22;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 22;

    // Largest degree magnitude (radians input, 180/pi applied) fits in 45 bits.
    localparam int MAG_W  = 45;
    localparam int PROD_W = 78;

    // 180/pi in Q32, split into two 19-bit halves for the partial products.
    localparam logic [37:0] RAD_TO_DEG_Q32 = 38'd246083499208;
    localparam logic [18:0] RAD_TO_DEG_HI  = RAD_TO_DEG_Q32[37:19];
    localparam logic [18:0] RAD_TO_DEG_LO  = RAD_TO_DEG_Q32[18:0];

    // Sexagesimal limits.
    localparam logic [MIN_W-1:0] MAX_MIN      = 6'd59;
    localparam logic [8:0]       FULL_TURN    = 9'd360;
    localparam logic [8:0]       FULL_TURN_M1 = 9'd359;
    localparam logic [5:0]       HOURS_PER_DAY = 6'd24;

    // 2^12 is 1 modulo 45, so 12-bit chunks can be summed before reducing.
    localparam int FOLD_CHUNK = 12;
    localparam int FOLD_W     = 14;

    // Reciprocals for exact division of small values.
    localparam logic [12:0] RECIP45       = 13'd5826;
    localparam int          RECIP45_SHIFT = 18;
    localparam logic [11:0] RECIP15       = 12'd2185;
    localparam int          RECIP15_SHIFT = 15;

    // Input codes.
    localparam logic ACTION_DMS   = 1'b0;
    localparam logic ACTION_HMS   = 1'b1;
    localparam logic UNIT_DEGREES = 1'b0;
    localparam logic UNIT_RADIANS = 1'b1;

    // Result of the minutes and seconds split.
    typedef struct packed {
        logic [MIN_W-1:0] minutes;
        logic [SEC_W-1:0] seconds;
        logic             carry;
    } asx_split_t;

endpackage

// ----- hw/rtl/asx_in_if.sv -----
// Input channel of the angle to sexagesimal converter: one angle per beat.
// Depends on asx_pkg for the field widths.
interface asx_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [asx_pkg::ANGLE_W-1:0]  angle;
    logic                                unit_is_radians;
    logic                                action;

    modport source (output valid, angle, unit_is_radians, action, input ready);
    modport sink   (input valid, angle, unit_is_radians, action, output ready);
endinterface

// ----- hw/rtl/asx_out_if.sv -----
// Output channel of the angle to sexagesimal converter: one result per beat.
// Depends on asx_pkg for the field widths.
interface asx_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [asx_pkg::WHOLE_W-1:0]  whole_part;
    logic        [asx_pkg::MIN_W-1:0]    minutes;
    logic        [asx_pkg::SEC_W-1:0]    seconds;
    logic                                negative;

    modport source (output valid, whole_part, minutes, seconds, negative, input ready);
    modport sink   (input valid, whole_part, minutes, seconds, negative, output ready);
endinterface

// ----- hw/rtl/asx_min_split.sv -----
// Final split of a minutes value into minutes, seconds and a carry.
// Depends on asx_pkg for widths, limits and the split result struct.
module asx_min_split #(
    parameter int ANGLE_FRAC_BITS   = 24,
    parameter int SECONDS_FRAC_BITS = 16
) (
    input  logic [asx_pkg::MIN_W-1:0]   mbase,
    input  logic [ANGLE_FRAC_BITS-1:0]  rem,
    output asx_pkg::asx_split_t         split
);

    localparam int AFB   = ANGLE_FRAC_BITS;
    localparam int SFB   = SECONDS_FRAC_BITS;
    localparam int SX_W  = AFB + 6;
    localparam int EXT_W = asx_pkg::SEC_W + SX_W + SFB;
    localparam logic [SX_W-1:0] SEC_LIMIT = {asx_pkg::MAX_MIN, {AFB{1'b0}}};

    logic [SX_W-1:0]           sec_exact;
    logic [EXT_W-1:0]          sec_ext;
    logic                      sec_carry;
    logic [asx_pkg::MIN_W:0]   min_sum;

    // Seconds are the remainder times 60, rescaled to the seconds fraction.
    assign sec_exact = {rem, 6'd0} - {4'd0, rem, 2'd0};
    assign sec_ext   = {{asx_pkg::SEC_W{1'b0}}, sec_exact, {SFB{1'b0}}};
    assign sec_carry = sec_exact > SEC_LIMIT;
    assign min_sum   = {1'b0, mbase} + (asx_pkg::MIN_W + 1)'(sec_carry);

    always_comb
    begin
        split.seconds = sec_carry ? '0 : sec_ext[AFB +: asx_pkg::SEC_W];
        if (min_sum > {1'b0, asx_pkg::MAX_MIN})
        begin
            split.minutes = '0;
            split.carry   = 1'b1;
        end
        else
        begin
            split.minutes = min_sum[asx_pkg::MIN_W-1:0];
            split.carry   = 1'b0;
        end
    end

endmodule

// ----- hw/rtl/angle_to_sexagesimal_unit.sv -----
// Top level of the angle to sexagesimal converter: an eight-stage pipeline.
// Depends on asx_pkg, asx_in_if, asx_out_if, asx_min_split and the assert header.
//
//   channel   direction  beat carries
//   -------   ---------  -----------------------------------------------
//   sample    in         angle, unit_is_radians, action
//   result    out        whole_part, minutes, seconds, negative
//
// One beat is accepted per cycle while the result is not stalled, and each
// beat passes through the stage chain: magnitude, partial products of the
// 180/pi scaling, product sum, minutes and modulo fold, reciprocal divide by
// 45, turn wrap, divide by 15, and the final seconds split with its carries.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stalled result holds every stage that is full; an empty stage still takes
// data, so bubbles are squeezed out and nothing is lost or repeated.
module angle_to_sexagesimal_unit #(
    parameter int ANGLE_FRAC_BITS   = 24,
    parameter int SECONDS_FRAC_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    asx_in_if.sink     sample,
    asx_out_if.source  result
);

`include "angle_to_sexagesimal_unit_assert.svh"

    localparam int AFB     = ANGLE_FRAC_BITS;
    localparam int NSTAGE  = 8;
    localparam int WHL_W   = asx_pkg::MAG_W - AFB;
    localparam int XW      = WHL_W - 3;
    localparam int NCH     = (XW + asx_pkg::FOLD_CHUNK - 1) / asx_pkg::FOLD_CHUNK;
    localparam int XP_W    = NCH * asx_pkg::FOLD_CHUNK;
    localparam int W22     = asx_pkg::WHOLE_W;

    typedef struct packed {
        logic [asx_pkg::ANGLE_W-1:0] mag;
        logic                        neg;
        logic                        rad;
        logic                        hms;
    } st1_t;

    typedef struct packed {
        logic [asx_pkg::ANGLE_W-1:0] mag;
        logic [38:0]                 pp_hh;
        logic [38:0]                 pp_hl;
        logic [38:0]                 pp_lh;
        logic [38:0]                 pp_ll;
        logic                        neg;
        logic                        rad;
        logic                        hms;
    } st2_t;

    typedef struct packed {
        logic [WHL_W-1:0] whole;
        logic [AFB-1:0]   frac;
        logic             neg;
        logic             hms;
    } st3_t;

    typedef struct packed {
        logic [asx_pkg::FOLD_W-1:0] fold;
        logic [2:0]                 low3;
        logic [AFB-1:0]             frac;
        logic [W22-1:0]             whole22;
        logic [5:0]                 dms_mbase;
        logic [AFB-1:0]             dms_rem;
        logic                       neg;
        logic                       hms;
    } st4_t;

    typedef struct packed {
        logic [12:0]    y;
        logic [7:0]     q;
        logic [2:0]     low3;
        logic [AFB-1:0] frac;
        logic [W22-1:0] whole22;
        logic [5:0]     dms_mbase;
        logic [AFB-1:0] dms_rem;
        logic           neg;
        logic           hms;
    } st5_t;

    typedef struct packed {
        logic [8:0]     w;
        logic [AFB-1:0] frac;
        logic [W22-1:0] whole22;
        logic [5:0]     dms_mbase;
        logic [AFB-1:0] dms_rem;
        logic           neg;
        logic           hms;
    } st6_t;

    typedef struct packed {
        logic [W22-1:0] whole22;
        logic [5:0]     mbase;
        logic [AFB-1:0] rem;
        logic           neg;
        logic           hms;
    } st7_t;

    typedef struct packed {
        logic [W22-1:0]              whole_part;
        logic [asx_pkg::MIN_W-1:0]   minutes;
        logic [asx_pkg::SEC_W-1:0]   seconds;
        logic                        negative;
    } res_t;

    logic [NSTAGE:1]   valid_reg;
    logic [NSTAGE:1]   valid_next;
    logic [NSTAGE+1:1] stage_en;

    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    st5_t s5_reg, s5_next;
    st6_t s6_reg, s6_next;
    st7_t s7_reg, s7_next;
    res_t out_reg, out_next;

    asx_pkg::asx_split_t split;

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb
    begin
        stage_en[NSTAGE+1] = result.ready;
        for (int i = NSTAGE; i >= 1; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[1])
        begin
            valid_next[1] = sample.valid;
        end
        for (int i = 2; i <= NSTAGE; i++)
        begin
            if (stage_en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: sign and magnitude of the angle.
    always_comb
    begin
        s1_next = s1_reg;
        if (stage_en[1])
        begin
            s1_next.neg = sample.angle[asx_pkg::ANGLE_W-1];
            s1_next.mag = s1_next.neg ? (~sample.angle + 1'b1) : sample.angle;
            s1_next.rad = (sample.unit_is_radians == asx_pkg::UNIT_RADIANS);
            s1_next.hms = (sample.action == asx_pkg::ACTION_HMS);
        end
    end

    // Stage 2: four 20 by 19 bit partial products of magnitude times 180/pi.
    always_comb
    begin
        s2_next = s2_reg;
        if (stage_en[2])
        begin
            s2_next.mag   = s1_reg.mag;
            s2_next.pp_hh = 39'(s1_reg.mag[39:20]) * 39'(asx_pkg::RAD_TO_DEG_HI);
            s2_next.pp_hl = 39'(s1_reg.mag[39:20]) * 39'(asx_pkg::RAD_TO_DEG_LO);
            s2_next.pp_lh = 39'(s1_reg.mag[19:0]) * 39'(asx_pkg::RAD_TO_DEG_HI);
            s2_next.pp_ll = 39'(s1_reg.mag[19:0]) * 39'(asx_pkg::RAD_TO_DEG_LO);
            s2_next.neg   = s1_reg.neg;
            s2_next.rad   = s1_reg.rad;
            s2_next.hms   = s1_reg.hms;
        end
    end

    // Stage 3: sum the products, drop 32 fraction bits for a radian input, split whole and fraction.
    logic [asx_pkg::PROD_W-1:0] prod;
    logic [asx_pkg::MAG_W-1:0]  deg;

    assign prod = (asx_pkg::PROD_W'(s2_reg.pp_hh) << 39)
                + (asx_pkg::PROD_W'(s2_reg.pp_hl) << 20)
                + (asx_pkg::PROD_W'(s2_reg.pp_lh) << 19)
                +  asx_pkg::PROD_W'(s2_reg.pp_ll);
    assign deg  = s2_reg.rad ? prod[asx_pkg::MAG_W+31:32] : asx_pkg::MAG_W'(s2_reg.mag);

    always_comb
    begin
        s3_next = s3_reg;
        if (stage_en[3])
        begin
            s3_next.whole = deg[asx_pkg::MAG_W-1:AFB];
            s3_next.frac  = deg[AFB-1:0];
            s3_next.neg   = s2_reg.neg;
            s3_next.hms   = s2_reg.hms;
        end
    end

    // Stage 4: degree minutes as fraction times 60; fold whole/8 modulo 45.
    logic [AFB+5:0]      frac60;
    logic [XP_W-1:0]     x_pad;
    logic [WHL_W+21:0]   whole_wide;
    logic [asx_pkg::FOLD_W-1:0] fold;

    assign frac60     = {s3_reg.frac, 6'd0} - {4'd0, s3_reg.frac, 2'd0};
    assign x_pad      = XP_W'(s3_reg.whole[WHL_W-1:3]);
    assign whole_wide = {22'd0, s3_reg.whole};

    always_comb
    begin
        fold = '0;
        for (int i = 0; i < NCH; i++)
        begin
            fold = fold + asx_pkg::FOLD_W'(x_pad[i*asx_pkg::FOLD_CHUNK +: asx_pkg::FOLD_CHUNK]);
        end
    end

    always_comb
    begin
        s4_next = s4_reg;
        if (stage_en[4])
        begin
            s4_next.fold      = fold;
            s4_next.low3      = s3_reg.whole[2:0];
            s4_next.frac      = s3_reg.frac;
            s4_next.whole22   = whole_wide[W22-1:0];
            s4_next.dms_mbase = frac60[AFB+5:AFB];
            s4_next.dms_rem   = frac60[AFB-1:0];
            s4_next.neg       = s3_reg.neg;
            s4_next.hms       = s3_reg.hms;
        end
    end

    // Stage 5: second fold, then quotient by 45 through its reciprocal.
    logic [12:0] y5;
    logic [25:0] yq;

    assign y5 = 13'(s4_reg.fold[11:0]) + 13'(s4_reg.fold[asx_pkg::FOLD_W-1:12]);
    assign yq = 26'(y5) * 26'(asx_pkg::RECIP45);

    always_comb
    begin
        s5_next = s5_reg;
        if (stage_en[5])
        begin
            s5_next.y         = y5;
            s5_next.q         = yq[25:asx_pkg::RECIP45_SHIFT];
            s5_next.low3      = s4_reg.low3;
            s5_next.frac      = s4_reg.frac;
            s5_next.whole22   = s4_reg.whole22;
            s5_next.dms_mbase = s4_reg.dms_mbase;
            s5_next.dms_rem   = s4_reg.dms_rem;
            s5_next.neg       = s4_reg.neg;
            s5_next.hms       = s4_reg.hms;
        end
    end

    // Stage 6: degrees modulo 360, then a negative angle is wrapped up.
    logic [12:0] q45;
    logic [12:0] r45;
    logic [8:0]  w360;

    assign q45  = {s5_reg.q, 5'd0} + {2'd0, s5_reg.q, 3'd0}
                + {3'd0, s5_reg.q, 2'd0} + 13'(s5_reg.q);
    assign r45  = s5_reg.y - q45;
    assign w360 = {r45[5:0], s5_reg.low3};

    always_comb
    begin
        s6_next = s6_reg;
        if (stage_en[6])
        begin
            s6_next.w    = w360;
            s6_next.frac = s5_reg.frac;
            if (s5_reg.neg && (w360 != '0 || s5_reg.frac != '0))
            begin
                s6_next.w    = ((s5_reg.frac == '0) ? asx_pkg::FULL_TURN
                                                    : asx_pkg::FULL_TURN_M1) - w360;
                s6_next.frac = ~s5_reg.frac + 1'b1;
            end
            s6_next.whole22   = s5_reg.whole22;
            s6_next.dms_mbase = s5_reg.dms_mbase;
            s6_next.dms_rem   = s5_reg.dms_rem;
            s6_next.neg       = s5_reg.neg;
            s6_next.hms       = s5_reg.hms;
        end
    end

    // Stage 7: in HMS mode, hours as degrees over 15; the remainder times 4 starts the minutes.
    logic [20:0] wq;
    logic [5:0]  hours;
    logic [9:0]  h15;
    logic [9:0]  r15;

    assign wq    = 21'(s6_reg.w) * 21'(asx_pkg::RECIP15);
    assign hours = wq[20:asx_pkg::RECIP15_SHIFT];
    assign h15   = {hours, 4'd0} - 10'(hours);
    assign r15   = 10'(s6_reg.w) - h15;

    always_comb
    begin
        s7_next = s7_reg;
        if (stage_en[7])
        begin
            if (s6_reg.hms)
            begin
                s7_next.whole22 = W22'(hours);
                s7_next.mbase   = {r15[3:0], s6_reg.frac[AFB-1 -: 2]};
                s7_next.rem     = {s6_reg.frac[AFB-3:0], 2'b00};
            end
            else
            begin
                s7_next.whole22 = s6_reg.whole22;
                s7_next.mbase   = s6_reg.dms_mbase;
                s7_next.rem     = s6_reg.dms_rem;
            end
            s7_next.neg = s6_reg.neg;
            s7_next.hms = s6_reg.hms;
        end
    end

    // Stage 8: seconds, both carries, and the sign back on the degrees.
    asx_min_split #(
        .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS),
        .SECONDS_FRAC_BITS (SECONDS_FRAC_BITS)
    ) u_min_split (
        .mbase (s7_reg.mbase),
        .rem   (s7_reg.rem),
        .split (split)
    );

    logic [W22-1:0] whole_sum;

    assign whole_sum = s7_reg.whole22 + W22'(split.carry);

    always_comb
    begin
        out_next = out_reg;
        if (stage_en[8])
        begin
            out_next.whole_part = (s7_reg.neg && !s7_reg.hms) ? (~whole_sum + 1'b1)
                                                             : whole_sum;
            out_next.minutes    = split.minutes;
            out_next.seconds    = split.seconds;
            out_next.negative   = s7_reg.neg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        s3_reg  <= s3_next;
        s4_reg  <= s4_next;
        s5_reg  <= s5_next;
        s6_reg  <= s6_next;
        s7_reg  <= s7_next;
        out_reg <= out_next;
    end

    assign sample.ready      = stage_en[1];
    assign result.valid      = valid_reg[NSTAGE];
    assign result.whole_part = out_reg.whole_part;
    assign result.minutes    = out_reg.minutes;
    assign result.seconds    = out_reg.seconds;
    assign result.negative   = out_reg.negative;

    // Minutes never leave 0..59 after the carries.
    `ASX_ASSERT_SAME(a_minutes_range, clk, rst_n, result.valid,
        result.minutes <= asx_pkg::MAX_MIN, "minutes above 59")
    // The wrapped angle stays inside one turn.
    `ASX_ASSERT_SAME(a_wrap_range, clk, rst_n, valid_reg[6] && s6_reg.hms,
        s6_reg.w < asx_pkg::FULL_TURN, "wrapped degrees outside one turn")
    // Before the minutes carry, hours stay below a full day.
    `ASX_ASSERT_SAME(a_hours_range, clk, rst_n, valid_reg[7] && s7_reg.hms,
        s7_reg.whole22 < W22'(asx_pkg::HOURS_PER_DAY), "hours before carry above 23")
    // The input is only held off when a result is waiting on the output.
    `ASX_ASSERT_SAME(a_backpressure_source, clk, rst_n, !sample.ready,
        result.valid && !result.ready, "input stalled without output stall")
    // An empty pipeline with no new beat cannot produce a result.
    `ASX_ASSERT_NEXT(a_no_phantom, clk, rst_n,
        valid_reg == '0 && !(sample.valid && sample.ready),
        !result.valid, "result without an accepted beat")

endmodule
